// ----- sv/lfu_cache_policy_unit_macros.svh -----
// ----------------------------------------------------------------------------
// LFU cache policy unit - assertion macros
// Wraps concurrent implication checks so they drop out when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_POLICY_UNIT_MACROS_SVH
`define LFU_CACHE_POLICY_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define LFU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfu_cache_policy_unit: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define LFU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfu_cache_policy_unit: next-cycle check failed");

`else

`define LFU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LFU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// LFU cache policy package
// Shared field widths, codes, sequencer states and control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfu_pkg;

  // Fixed field widths
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  // Request modes
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_COMMIT
  } lfu_state_e;

  // Table action chosen after the scan
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_BUMP,
    ACT_INSERT
  } lfu_act_e;

  // Kind of recency-rank sweep
  typedef enum logic {
    SW_PROMOTE,
    SW_INSERT
  } lfu_sweep_e;

  // Controls from the sequencer into the entry unit
  typedef struct packed {
    logic       found;
    logic       have;
    logic       free_found;
    logic       is_target;
    logic       is_victim;
    logic       evict;
    lfu_sweep_e sweep;
  } lfu_ctl_t;

  // Per-entry verdicts back to the sequencer
  typedef struct packed {
    logic match;
    logic better;
    logic free;
    logic rank_we;
  } lfu_flags_t;

endpackage

// ----- sv/lfu_cache_policy_unit.sv -----
// ----------------------------------------------------------------------------
// LFU cache policy unit
// A key/value table with least-frequently-used replacement and least-recently
// used tie break. Pulse start while busy is low to issue a get (mode 0) or put
// (mode 1); busy stays high until the result, which appears on the result
// ports for exactly one cycle with done_o high and cannot be held off. Each
// request makes one pass over the table, one entry per cycle through the
// shared compare unit, to search for the key, victim and free slot. When
// ranks change (a get hit, or a put that updates or inserts) a second pass
// rewrites the recency ranks. Both passes go through the single read port of
// the entry tables. The user must write capacity through cfg_we_i/cfg_data_i
// only while the unit is idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lfu_cache_policy_unit_macros.svh"

module lfu_cache_policy_unit #(
  parameter int ENTRIES     = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      mode_i,
  input  logic [lfu_pkg::KEY_W-1:0] key_i,
  input  logic [lfu_pkg::VAL_W-1:0] value_i,
  input  logic                      cfg_we_i,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_data_i,
  output logic                      done_o,
  output logic                      hit_o,
  output logic [lfu_pkg::VAL_W-1:0] read_value_o,
  output logic                      evicted_o,
  output logic [lfu_pkg::KEY_W-1:0] evicted_key_o
);
  import lfu_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Sequencer and configuration
  lfu_state_e         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CAP_W-1:0]   cap_q;
  logic [CNT_W-1:0]   occ_q;
  logic [ENTRIES-1:0] valid_q;
  logic               done_q;

  // Request beat
  logic               mode_q;
  logic [KEY_W-1:0]   key_q;
  logic [VAL_W-1:0]   value_q;

  // Scan results
  logic               found_q, have_q, free_found_q;
  logic [IDX_W-1:0]   slot_q, vic_q, free_q;
  logic [RANK_W-1:0]  slot_rank_q, vic_rank_q;
  logic [COUNT_WIDTH-1:0] slot_cnt_q, vic_cnt_q;
  logic [VAL_W-1:0]   slot_val_q;
  logic [KEY_W-1:0]   vic_key_q;

  // Decision
  lfu_act_e           act_q, act_d;
  logic               evict_q, evict_d;
  logic [IDX_W-1:0]   target_q, target_d;

  // Result registers
  logic               hit_q;
  logic [VAL_W-1:0]   rval_q;
  logic               evd_q;
  logic [KEY_W-1:0]   evkey_q;

  // Entry tables and their read stage
  logic [KEY_W-1:0]       key_mem  [ENTRIES];
  logic [VAL_W-1:0]       val_mem  [ENTRIES];
  logic [COUNT_WIDTH-1:0] cnt_mem  [ENTRIES];
  logic [RANK_W-1:0]      rank_mem [ENTRIES];
  logic [KEY_W-1:0]       key_rd_q;
  logic [VAL_W-1:0]       val_rd_q;
  logic [COUNT_WIDTH-1:0] cnt_rd_q;
  logic [RANK_W-1:0]      rank_rd_q;
  logic [IDX_W-1:0]       pidx_q;

  // Sequencer outputs
  logic               last;
  logic               scan_en, upd_en, commit_en;
  logic [IDX_W-1:0]   rd_idx;

  // Entry unit hookup
  lfu_ctl_t           ctl;
  lfu_flags_t         flags;
  logic [RANK_W-1:0]  new_rank;
  logic [RANK_W-1:0]  pivot_rank;

  // Decision helpers
  logic [CMP_W-1:0]       cap_ext, cap_eff, occ_ext;
  logic                   full;
  logic [COUNT_WIDTH-1:0] slot_cnt_inc;

  assign last = (cnt_q == CNT_W'(ENTRIES));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = (act_d != ACT_NONE) ? ST_UPDATE : ST_COMMIT;
      end
      ST_UPDATE: begin
        if (last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy      = 1'b1;
    scan_en   = 1'b0;
    upd_en    = 1'b0;
    commit_en = 1'b0;
    cnt_d     = '0;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_SCAN: begin
        scan_en = (cnt_q != '0);
        cnt_d   = last ? '0 : cnt_q + CNT_W'(1);
      end
      ST_DECIDE: begin
        cnt_d = '0;
      end
      ST_UPDATE: begin
        upd_en = (cnt_q != '0);
        cnt_d  = last ? '0 : cnt_q + CNT_W'(1);
      end
      ST_COMMIT: begin
        commit_en = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign rd_idx = cnt_q[IDX_W-1:0];

  // Decide the action from the scan
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    cap_eff = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
    occ_ext = CMP_W'(occ_q);
    full    = (occ_ext >= cap_eff);
    evict_d = 1'b0;
    act_d   = ACT_NONE;
    if (mode_q == MODE_GET) begin
      act_d = found_q ? ACT_BUMP : ACT_NONE;
    end else if (cap_q == '0) begin
      act_d = ACT_NONE;
    end else if (found_q) begin
      act_d = ACT_BUMP;
    end else begin
      evict_d = full && have_q;
      act_d   = (evict_d || free_found_q) ? ACT_INSERT : ACT_NONE;
    end
    if (found_q) begin
      target_d = slot_q;
    end else if (evict_d) begin
      target_d = (free_found_q && (free_q < vic_q)) ? free_q : vic_q;
    end else begin
      target_d = free_q;
    end
  end

  assign slot_cnt_inc = (&slot_cnt_q) ? slot_cnt_q : slot_cnt_q + COUNT_WIDTH'(1);

  // Drive the shared entry unit
  always_comb begin
    ctl.found      = found_q;
    ctl.have       = have_q;
    ctl.free_found = free_found_q;
    ctl.is_target  = (pidx_q == target_q);
    ctl.is_victim  = (pidx_q == vic_q);
    ctl.evict      = evict_q;
    ctl.sweep      = (act_q == ACT_INSERT) ? SW_INSERT : SW_PROMOTE;
  end

  assign pivot_rank = (act_q == ACT_INSERT) ? vic_rank_q : slot_rank_q;

  lfu_entry_unit #(
    .ENTRIES     (ENTRIES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_entry (
    .e_valid_i    (valid_q[pidx_q]),
    .e_key_i      (key_rd_q),
    .e_count_i    (cnt_rd_q),
    .e_rank_i     (rank_rd_q),
    .search_key_i (key_q),
    .best_count_i (vic_cnt_q),
    .best_rank_i  (vic_rank_q),
    .pivot_rank_i (pivot_rank),
    .ctl_i        (ctl),
    .flags_o      (flags),
    .new_rank_o   (new_rank)
  );

  // Control state: sequencer, capacity, occupancy, valid bits, scan flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      cap_q        <= CAP_RESET;
      occ_q        <= '0;
      valid_q      <= '0;
      done_q       <= 1'b0;
      found_q      <= 1'b0;
      have_q       <= 1'b0;
      free_found_q <= 1'b0;
      act_q        <= ACT_NONE;
      evict_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= commit_en;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      // Clear scan flags on a new beat
      if (state_q == ST_IDLE && start) begin
        found_q      <= 1'b0;
        have_q       <= 1'b0;
        free_found_q <= 1'b0;
      end
      if (scan_en) begin
        if (flags.match) begin
          found_q <= 1'b1;
        end
        if (flags.better) begin
          have_q <= 1'b1;
        end
        if (flags.free) begin
          free_found_q <= 1'b1;
        end
      end
      if (state_q == ST_DECIDE) begin
        act_q   <= act_d;
        evict_q <= evict_d;
      end
      // Retire the victim and claim the target slot
      if (commit_en && act_q == ACT_INSERT) begin
        if (evict_q && (vic_q != target_q)) begin
          valid_q[vic_q] <= 1'b0;
        end
        valid_q[target_q] <= 1'b1;
        if (!evict_q) begin
          occ_q <= occ_q + CNT_W'(1);
        end
      end
    end
  end

  // Payload: request beat, scan captures, results
  always_ff @(posedge clk_i) begin
    pidx_q <= rd_idx;
    if (state_q == ST_IDLE && start) begin
      mode_q  <= mode_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (scan_en) begin
      if (flags.match) begin
        slot_q      <= pidx_q;
        slot_rank_q <= rank_rd_q;
        slot_cnt_q  <= cnt_rd_q;
        slot_val_q  <= val_rd_q;
      end
      if (flags.better) begin
        vic_q      <= pidx_q;
        vic_cnt_q  <= cnt_rd_q;
        vic_rank_q <= rank_rd_q;
        vic_key_q  <= key_rd_q;
      end
      if (flags.free) begin
        free_q <= pidx_q;
      end
    end
    if (state_q == ST_DECIDE) begin
      target_q <= target_d;
      hit_q    <= found_q;
      rval_q   <= (mode_q == MODE_GET && found_q) ? slot_val_q : '0;
      evd_q    <= evict_d;
      evkey_q  <= evict_d ? vic_key_q : '0;
    end
  end

  // Entry tables: one registered read, writes from the sweep and commit
  always_ff @(posedge clk_i) begin
    key_rd_q  <= key_mem[rd_idx];
    val_rd_q  <= val_mem[rd_idx];
    cnt_rd_q  <= cnt_mem[rd_idx];
    rank_rd_q <= rank_mem[rd_idx];
    if (upd_en && flags.rank_we) begin
      rank_mem[pidx_q] <= new_rank;
    end
    if (commit_en) begin
      case (act_q)
        ACT_BUMP: begin
          cnt_mem[target_q] <= slot_cnt_inc;
          if (mode_q == MODE_PUT) begin
            val_mem[target_q] <= value_q;
          end
        end
        ACT_INSERT: begin
          key_mem[target_q] <= key_q;
          val_mem[target_q] <= value_q;
          cnt_mem[target_q] <= COUNT_WIDTH'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign read_value_o  = rval_q;
  assign evicted_o     = evd_q;
  assign evicted_key_o = evkey_q;

  // Checks
  `LFU_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `LFU_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `LFU_ASSERT_IMP(a_evict_miss, clk_i, rst_ni, done_o && evicted_o, !hit_o)
  `LFU_ASSERT_IMP(a_occ_valid, clk_i, rst_ni, state_q == ST_IDLE, $countones(valid_q) == int'(occ_q))
  `LFU_ASSERT_IMP(a_occ_bound, clk_i, rst_ni, state_q == ST_COMMIT, occ_q <= CNT_W'(ENTRIES))

endmodule

// ----- sv/lfu_entry_unit.sv -----
// ----------------------------------------------------------------------------
// LFU entry unit
// Shared compare and rank-update unit: judges one table entry per cycle for
// key match, victim preference and free slot, and computes its new rank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_entry_unit #(
  parameter int  ENTRIES     = 16,
  parameter int  COUNT_WIDTH = 16,
  localparam int RANK_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                      e_valid_i,
  input  logic [lfu_pkg::KEY_W-1:0] e_key_i,
  input  logic [COUNT_WIDTH-1:0]    e_count_i,
  input  logic [RANK_W-1:0]         e_rank_i,
  input  logic [lfu_pkg::KEY_W-1:0] search_key_i,
  input  logic [COUNT_WIDTH-1:0]    best_count_i,
  input  logic [RANK_W-1:0]         best_rank_i,
  input  logic [RANK_W-1:0]         pivot_rank_i,
  input  lfu_pkg::lfu_ctl_t         ctl_i,
  output lfu_pkg::lfu_flags_t       flags_o,
  output logic [RANK_W-1:0]         new_rank_o
);
  import lfu_pkg::*;

  logic [RANK_W-1:0] rank_inc;

  assign rank_inc = e_rank_i + RANK_W'(1);

  // Judge the entry: first match, better victim, first free slot
  always_comb begin
    flags_o.match  = e_valid_i && (e_key_i == search_key_i) && !ctl_i.found;
    flags_o.better = e_valid_i &&
                     (!ctl_i.have || (e_count_i < best_count_i) ||
                      ((e_count_i == best_count_i) && (e_rank_i > best_rank_i)));
    flags_o.free   = !e_valid_i && !ctl_i.free_found;
    // Write back every surviving entry plus the target slot
    flags_o.rank_we = ctl_i.is_target ||
                      (e_valid_i && !(ctl_i.evict && ctl_i.is_victim));
  end

  // Compute the rank after promotion or insertion
  always_comb begin
    case (ctl_i.sweep)
      SW_PROMOTE: begin
        if (ctl_i.is_target) begin
          new_rank_o = '0;
        end else if (e_rank_i < pivot_rank_i) begin
          new_rank_o = rank_inc;
        end else begin
          new_rank_o = e_rank_i;
        end
      end
      SW_INSERT: begin
        if (ctl_i.is_target) begin
          new_rank_o = '0;
        end else if (ctl_i.evict && (e_rank_i > pivot_rank_i)) begin
          // older than the victim: the eviction and the insert cancel out
          new_rank_o = e_rank_i;
        end else begin
          new_rank_o = rank_inc;
        end
      end
      default: begin
        new_rank_o = e_rank_i;
      end
    endcase
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache policy unit testbench
// Drives get/put requests through the start/busy handshake and rewrites the
// capacity register between phases. A scoreboard class keeps a shadow copy of
// the table (keys, values, use counts, recency ranks) and predicts every
// response; each done_o beat is compared field by field with the oldest one.
// ----------------------------------------------------------------------------

module tb_top;
  import lfu_pkg::*;

  localparam int N_ENTRIES  = 16;
  localparam int COUNT_W    = 16;
  localparam int POOL_SIZE  = 24;
  localparam int TAIL_WAIT  = 2 * N_ENTRIES + 8;
  localparam int CYCLE_CAP  = 400000;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } lfu_result_t;

  // Shadow table and queue of predicted responses
  class lfu_scoreboard;
    bit               valid[N_ENTRIES];
    logic [KEY_W-1:0] keys[N_ENTRIES];
    logic [VAL_W-1:0] vals[N_ENTRIES];
    logic [COUNT_W-1:0] uses[N_ENTRIES];
    int unsigned      ranks[N_ENTRIES];
    int unsigned      occupied;
    logic [CAP_W-1:0] capacity = CAP_RESET;
    lfu_result_t      pending[$];
    int unsigned      mismatches;

    // Make slot s most recent and count one more use
    function void touch(int s);
      if (uses[s] < COUNT_MAX) uses[s]++;
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (valid[i] && i != s && ranks[i] < ranks[s]) ranks[i]++;
      end
      ranks[s] = 0;
    endfunction

    // Predict the response of one accepted request and update the table
    function void note_request(logic mode, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      lfu_result_t r;
      int unsigned cap;
      int          slot;
      int          victim;
      int          free_slot;
      bit          found;
      bit          have;
      int unsigned vr;
      r = '0;
      cap = (capacity > N_ENTRIES) ? N_ENTRIES : capacity;
      found = 0;
      slot = 0;
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (!found && valid[i] && keys[i] == k) begin
          found = 1;
          slot = i;
        end
      end
      r.hit = found;
      if (mode == MODE_GET) begin
        if (found) begin
          r.read_value = vals[slot];
          touch(slot);
        end
      end else if (cap != 0) begin
        if (found) begin
          vals[slot] = v;
          touch(slot);
        end else begin
          // Evict the least used entry, oldest first among equals
          if (occupied >= cap) begin
            have = 0;
            victim = 0;
            for (int i = 0; i < N_ENTRIES; i++) begin
              if (valid[i] && (!have || uses[i] < uses[victim] ||
                  (uses[i] == uses[victim] && ranks[i] > ranks[victim]))) begin
                victim = i;
                have = 1;
              end
            end
            if (have) begin
              vr = ranks[victim];
              valid[victim] = 0;
              if (occupied > 0) occupied--;
              for (int i = 0; i < N_ENTRIES; i++) begin
                if (valid[i] && ranks[i] > vr) ranks[i]--;
              end
              r.evicted = 1'b1;
              r.evicted_key = keys[victim];
            end
          end
          // Fill the lowest free slot
          free_slot = -1;
          for (int i = 0; i < N_ENTRIES; i++) begin
            if (free_slot < 0 && !valid[i]) free_slot = i;
          end
          if (free_slot >= 0) begin
            for (int i = 0; i < N_ENTRIES; i++) begin
              if (valid[i]) ranks[i]++;
            end
            valid[free_slot] = 1;
            keys[free_slot] = k;
            vals[free_slot] = v;
            uses[free_slot] = 1;
            ranks[free_slot] = 0;
            occupied++;
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void flag(string what, lfu_result_t exp_r, lfu_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] MISMATCH %s: exp hit=%0b rd=%h ev=%0b evk=%h", $realtime, what,
                 exp_r.hit, exp_r.read_value, exp_r.evicted, exp_r.evicted_key);
        $display("               got hit=%0b rd=%h ev=%0b evk=%h",
                 got.hit, got.read_value, got.evicted, got.evicted_key);
      end
    endfunction

    // Compare one response beat with the oldest prediction
    function void check_response(lfu_result_t got);
      lfu_result_t exp_r;
      if (pending.size() == 0) begin
        flag("unexpected response", '0, got);
      end else begin
        exp_r = pending.pop_front();
        if (got.hit !== exp_r.hit) flag("hit", exp_r, got);
        if (got.read_value !== exp_r.read_value) flag("read_value", exp_r, got);
        if (got.evicted !== exp_r.evicted) flag("evicted", exp_r, got);
        if (got.evicted_key !== exp_r.evicted_key) flag("evicted_key", exp_r, got);
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             mode_i = MODE_GET;
  logic [KEY_W-1:0] key_i = '0;
  logic [VAL_W-1:0] value_i = '0;
  logic             cfg_we_i = 1'b0;
  logic [CAP_W-1:0] cfg_data_i = '0;
  logic             done_o;
  logic             hit_o;
  logic [VAL_W-1:0] read_value_o;
  logic             evicted_o;
  logic [KEY_W-1:0] evicted_key_o;

  lfu_scoreboard    sb = new();
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  int unsigned      cycles;

  lfu_cache_policy_unit #(
    .ENTRIES    (N_ENTRIES),
    .COUNT_WIDTH(COUNT_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .read_value_o (read_value_o),
    .evicted_o    (evicted_o),
    .evicted_key_o(evicted_key_o)
  );

  always #10 clk_i = ~clk_i;

  // Check every response beat
  always @(posedge clk_i) begin : response_monitor
    lfu_result_t got;
    if (rst_ni && done_o) begin
      got.hit = hit_o;
      got.read_value = read_value_o;
      got.evicted = evicted_o;
      got.evicted_key = evicted_key_o;
      sb.check_response(got);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one request and hold it until the accepting edge
  task automatic issue(logic m, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    start <= 1'b1;
    mode_i <= m;
    key_i <= k;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    sb.note_request(m, k, v);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Hold off until every predicted response has arrived and the unit is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= c;
    @(posedge clk_i);
    sb.capacity = c;
    cfg_we_i <= 1'b0;
  endtask

  // Random traffic over a pool of hot keys with some cold misses
  task automatic run_phase(logic [CAP_W-1:0] c, int pool_n, int n_items, bit idle_on,
                           bit hold_midway);
    logic             m;
    logic [KEY_W-1:0] k;
    set_capacity(c);
    for (int n = 0; n < n_items; n++) begin
      m = ($urandom_range(99) < 55) ? MODE_PUT : MODE_GET;
      k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_n - 1)] : $urandom;
      issue(m, k, $urandom);
      if (hold_midway && n == n_items / 2) drain();
      else if (idle_on && $urandom_range(99) < 21) pause($urandom_range(1, 40));
    end
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Basic gets and puts at the key and value extremes
    set_capacity(5'd16);
    issue(MODE_GET, 32'h0000_0000, 32'h0);
    issue(MODE_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(MODE_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    issue(MODE_GET, 32'h0000_0000, 32'hDEAD_BEEF);
    issue(MODE_PUT, 32'h0000_0000, 32'h1234_5678);
    issue(MODE_GET, 32'hFFFF_FFFF, 32'h0);
    issue(MODE_GET, 32'h0000_0005, 32'h0);

    // Full table: least used goes, then oldest among equal counts
    set_capacity(5'd2);
    issue(MODE_PUT, 32'hA5A5_0001, 32'h1111_1111);
    issue(MODE_PUT, 32'hA5A5_0002, 32'h2222_2222);

    // Zero capacity: puts change nothing, presence is still reported
    set_capacity(5'd0);
    issue(MODE_PUT, 32'h0000_0000, 32'h3333_3333);
    issue(MODE_PUT, 32'hA5A5_0003, 32'h4444_4444);
    issue(MODE_GET, 32'h0000_0000, 32'h0);

    // Capacity above the table size saturates
    set_capacity(5'd31);
    for (int i = 0; i < 6; i++) issue(MODE_PUT, 32'h5A5A_B000 + i, $urandom);
    issue(MODE_GET, 32'h5A5A_B002, 32'h0);
    issue(MODE_GET, 32'h5A5A_B004, 32'h0);

    // Capacity lowered below occupancy: one victim per missing put
    set_capacity(5'd3);
    issue(MODE_PUT, 32'hC0C0_0000, $urandom);
    issue(MODE_PUT, 32'hC0C0_0001, $urandom);
    issue(MODE_PUT, 32'h5A5A_B002, $urandom);
    set_capacity(5'd1);
    issue(MODE_PUT, 32'hD0D0_0000, $urandom);
    issue(MODE_GET, 32'hD0D0_0000, 32'h0);

    // Random phases over several capacities
    run_phase(5'd16, 20, 100, 1'b1, 1'b0);
    run_phase(5'd4, 8, 100, 1'b0, 1'b0);
    run_phase(5'd1, 3, 60, 1'b1, 1'b0);
    run_phase(5'd0, 8, 40, 1'b1, 1'b0);
    run_phase(5'd31, 24, 100, 1'b1, 1'b1);
    run_phase(5'd7, 12, 100, 1'b1, 1'b0);

    drain();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/lfu_pkg.sv
sv/lfu_entry_unit.sv
sv/lfu_cache_policy_unit.sv
tb/sv/tb_top.sv
